// ===== sv/bme_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and bracket decode for the bracket match engine.
// No dependencies.
package bme_pkg;

  localparam int FIELD_W = 16;

  typedef enum logic [2:0] {
    REQ_START_FWD = 3'd0,
    REQ_START_BWD = 3'd1,
    REQ_START_ENC = 3'd2,
    REQ_CHAR      = 3'd3,
    REQ_MARK      = 3'd4,
    REQ_END       = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_PAIR     = 2'd0,
    ST_NOMATCH  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_FWD = 2'd0,
    MODE_BWD = 2'd1,
    MODE_ENC = 2'd2
  } mode_t;

  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_BRACE  = 2'd2;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LSQ    = 8'h5B;
  localparam logic [7:0] CH_RSQ    = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } kind_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [7:0]         ch;
    logic               ignored;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] open_line;
    logic [FIELD_W-1:0] open_col;
    logic [FIELD_W-1:0] close_line;
    logic [FIELD_W-1:0] close_col;
  } result_t;

  function automatic kind_t open_kind(input logic [7:0] c);
    kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_PAREN;
    case (c)
      CH_LPAREN: k.kind = KIND_PAREN;
      CH_LSQ:    k.kind = KIND_SQUARE;
      CH_LBRACE: k.kind = KIND_BRACE;
      default:   k.hit  = 1'b0;
    endcase
    return k;
  endfunction

  function automatic kind_t close_kind(input logic [7:0] c);
    kind_t k;
    k.hit  = 1'b1;
    k.kind = KIND_PAREN;
    case (c)
      CH_RPAREN: k.kind = KIND_PAREN;
      CH_RSQ:    k.kind = KIND_SQUARE;
      CH_RBRACE: k.kind = KIND_BRACE;
      default:   k.hit  = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/bme_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bme_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bme_ctrl.sv =====
`timescale 1ns / 1ps
// Search control: nesting stack with cached top, search state and result decode.
// Depends on bme_pkg and bme_ram.
module bme_ctrl import bme_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int POS_WIDTH   = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    go,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam int AW      = $clog2(STACK_DEPTH);
  localparam int CW      = $clog2(STACK_DEPTH + 1);
  localparam int ENTRY_W = 2 + 2 * POS_WIDTH;

  logic [CW-1:0]        count, count_next;
  mode_t                mode, mode_next;
  logic                 active, active_next;
  logic [1:0]           wanted, wanted_next;
  logic [POS_WIDTH-1:0] anchor_line, anchor_line_next;
  logic [POS_WIDTH-1:0] anchor_col, anchor_col_next;

  logic                 byp;
  logic [ENTRY_W-1:0]   byp_data;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   top;
  logic [AW-1:0]        raddr;
  logic                 push;
  logic [ENTRY_W-1:0]   push_data;

  logic [POS_WIDTH-1:0] pos_line, pos_col;
  logic [1:0]           top_kind;
  logic [POS_WIDTH-1:0] top_line, top_col;
  kind_t                ok, ck, pk, mk;
  logic                 is_push;

  assign pos_line = POS_WIDTH'(item.line);
  assign pos_col  = POS_WIDTH'(item.col);
  assign ok       = open_kind(item.ch);
  assign ck       = close_kind(item.ch);

  assign top      = byp ? byp_data : rd_data;
  assign top_kind = top[ENTRY_W-1 -: 2];
  assign top_line = top[2*POS_WIDTH-1 -: POS_WIDTH];
  assign top_col  = top[POS_WIDTH-1:0];

  always_comb begin
    pk = (mode == MODE_BWD) ? ck : ok;
    mk = (mode == MODE_BWD) ? ok : ck;
    is_push = pk.hit;
  end

  always_comb begin
    count_next       = count;
    mode_next        = mode;
    active_next      = active;
    wanted_next      = wanted;
    anchor_line_next = anchor_line;
    anchor_col_next  = anchor_col;
    push             = 1'b0;
    push_data        = {pk.kind, pos_line, pos_col};
    res_valid        = 1'b0;
    res              = '0;
    res.status       = ST_NOMATCH;
    if (go) begin
      case (req_t'(item.req_type))
        REQ_START_FWD, REQ_START_BWD: begin
          count_next = '0;
          if (item.req_type == REQ_START_FWD ? ok.hit : ck.hit) begin
            mode_next        = (item.req_type == REQ_START_FWD) ? MODE_FWD : MODE_BWD;
            active_next      = 1'b1;
            wanted_next      = (item.req_type == REQ_START_FWD) ? ok.kind : ck.kind;
            anchor_line_next = pos_line;
            anchor_col_next  = pos_col;
          end else begin
            active_next = 1'b0;
            res_valid   = 1'b1;
          end
        end
        REQ_START_ENC: begin
          count_next       = '0;
          mode_next        = MODE_ENC;
          active_next      = 1'b1;
          wanted_next      = KIND_PAREN;
          anchor_line_next = '0;
          anchor_col_next  = '0;
        end
        REQ_END: begin
          if (active) begin
            active_next = 1'b0;
            res_valid   = 1'b1;
          end
        end
        REQ_MARK: begin
          if (active && mode == MODE_ENC) begin
            if (count == '0) begin
              active_next = 1'b0;
              res_valid   = 1'b1;
            end else begin
              count_next       = '0;
              mode_next        = MODE_FWD;
              wanted_next      = top_kind;
              anchor_line_next = top_line;
              anchor_col_next  = top_col;
            end
          end
        end
        REQ_CHAR: begin
          if (active && !item.ignored && (ok.hit || ck.hit)) begin
            if (is_push) begin
              if (count == CW'(STACK_DEPTH)) begin
                active_next = 1'b0;
                res_valid   = 1'b1;
                res.status  = ST_OVERFLOW;
              end else begin
                push       = 1'b1;
                count_next = count + 1'b1;
              end
            end else if (count == '0) begin
              if (mode != MODE_ENC) begin
                active_next = 1'b0;
                res_valid   = 1'b1;
                if (mk.kind == wanted) begin
                  res.status = ST_PAIR;
                  if (mode == MODE_FWD) begin
                    res.open_line  = FIELD_W'(anchor_line);
                    res.open_col   = FIELD_W'(anchor_col);
                    res.close_line = FIELD_W'(pos_line);
                    res.close_col  = FIELD_W'(pos_col);
                  end else begin
                    res.open_line  = FIELD_W'(pos_line);
                    res.open_col   = FIELD_W'(pos_col);
                    res.close_line = FIELD_W'(anchor_line);
                    res.close_col  = FIELD_W'(anchor_col);
                  end
                end
              end
            end else if (top_kind == mk.kind) begin
              count_next = count - 1'b1;
            end else begin
              active_next = 1'b0;
              res_valid   = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Read the entry that becomes the top after this cycle.
  assign raddr = (count_next == '0) ? '0 : AW'(count_next - 1'b1);

  bme_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (push),
    .waddr(AW'(count)),
    .wdata(push_data),
    .raddr(raddr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      mode        <= MODE_FWD;
      active      <= 1'b0;
      wanted      <= KIND_PAREN;
      anchor_line <= '0;
      anchor_col  <= '0;
      byp         <= 1'b0;
    end else begin
      count       <= count_next;
      mode        <= mode_next;
      active      <= active_next;
      wanted      <= wanted_next;
      anchor_line <= anchor_line_next;
      anchor_col  <= anchor_col_next;
      byp         <= push;
    end
    byp_data <= push_data;
  end

endmodule

// ===== sv/bracket_match_engine.sv =====
`timescale 1ns / 1ps
// Bracket match engine top level: input register, search control, result register.
// Depends on bme_pkg and bme_ctrl.
//
// Takes one item per clock while the result side does not stall, and gives at
// most one result per item, by way of the input register and then the
// result register. The nesting stack lives in a RAM with registered read;
// the top entry is prefetched from the next stack count each cycle and a
// one-entry bypass covers the entry pushed in the previous cycle, so a push,
// pop or top compare never waits on the RAM. Stalls on the result side hold
// the whole pipe. Stack overflow is reported as status 2, never wrapped.
module bracket_match_engine import bme_pkg::*; #(
  parameter int STACK_DEPTH = 64,
  parameter int POS_WIDTH   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         req_type,
  input  logic [7:0]         ch,
  input  logic               ignored,
  input  logic [FIELD_W-1:0] line,
  input  logic [FIELD_W-1:0] col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [FIELD_W-1:0] open_line,
  output logic [FIELD_W-1:0] open_col,
  output logic [FIELD_W-1:0] close_line,
  output logic [FIELD_W-1:0] close_col
);

  logic    adv;
  logic    s1_valid;
  item_t   s1_item;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_valid;
      out_valid <= res_valid;
    end
    if (adv && in_valid) begin
      s1_item <= '{req_type: req_type, ch: ch, ignored: ignored, line: line, col: col};
    end
    if (adv && res_valid) begin
      out_res <= res;
    end
  end

  bme_ctrl #(
    .STACK_DEPTH(STACK_DEPTH),
    .POS_WIDTH  (POS_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (s1_valid && adv),
    .item     (s1_item),
    .res_valid(res_valid),
    .res      (res)
  );

  assign status     = out_res.status;
  assign open_line  = out_res.open_line;
  assign open_col   = out_res.open_col;
  assign close_line = out_res.close_line;
  assign close_col  = out_res.close_col;

endmodule
